/* hw/rtl/khrf_pkg.sv */
// Package for the two-state hedge ratio filter: formats, sequencer states,
// shared arithmetic helpers. No dependencies.
package khrf_pkg;

  localparam int unsigned PriceW = 32;
  localparam int unsigned CovW   = 48;
  localparam int unsigned NoiseW = 44;
  localparam int unsigned AccW   = 64;

  localparam logic [0:0] CfgProcNoise = 1'b0;
  localparam logic [0:0] CfgMeasNoise = 1'b1;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_PRED,
    ST_M_SB,
    ST_M_BP11,
    ST_M_BPX,
    ST_M_BBP,
    ST_M_BP10,
    ST_M_BP01,
    ST_RES,
    ST_DIV0,
    ST_DIV0_W,
    ST_DIV1,
    ST_DIV1_W,
    ST_M_K0E,
    ST_M_K1E,
    ST_M_C00,
    ST_M_C01,
    ST_M_C10,
    ST_M_C11,
    ST_OUT
  } seq_state_e;

  // saturate a signed 128-bit value to w bits (w <= 64)
  function automatic logic signed [63:0] sat128(input logic signed [127:0] v,
                                                input int unsigned w);
    logic signed [127:0] hi;
    logic signed [127:0] lo;
    begin
      hi = (128'sd1 <<< (w - 1)) - 128'sd1;
      lo = -(128'sd1 <<< (w - 1));
      if (v > hi) sat128 = hi[63:0];
      else if (v < lo) sat128 = lo[63:0];
      else sat128 = v[63:0];
    end
  endfunction

  function automatic logic signed [63:0] sadd(input logic signed [63:0] a,
                                              input logic signed [63:0] b);
    logic signed [64:0] s;
    begin
      s = {a[63], a} + {b[63], b};
      sadd = sat128({{63{s[64]}}, s}, 64);
    end
  endfunction

endpackage

/* hw/rtl/khrf_mul.sv */
// Shared signed multiplier with round-half-away shift and saturation.
// Cut into four 32x32 partial products summed in an accumulator. Depends on khrf_pkg.
module khrf_mul
  import khrf_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [63:0] a_i,
  input  logic signed [63:0] b_i,
  input  logic [5:0]         sh_i,
  input  logic [6:0]         w_i,
  output logic               done_o,
  output logic signed [63:0] res_o
);
  logic [63:0]  ma_q, mb_q;
  logic         neg_q;
  logic [5:0]   sh_q;
  logic [6:0]   w_q;
  logic [127:0] acc_q;
  logic [2:0]   step_q;
  logic         busy_q;
  logic [31:0]  pa, pb;
  logic [63:0]  pp;
  logic [127:0] pps;
  logic [127:0] rnd;
  logic [127:0] mag;

  always_comb begin
    pa = step_q[0] ? ma_q[63:32] : ma_q[31:0];
    pb = step_q[1] ? mb_q[63:32] : mb_q[31:0];
    pp = pa * pb;
    pps = {64'd0, pp} << ({5'd0, step_q[0]} * 7'd32 + {5'd0, step_q[1]} * 7'd32);
    rnd = (sh_q == 6'd0) ? acc_q : ((acc_q + (128'd1 << (sh_q - 6'd1))) >> sh_q);
    mag = rnd;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
      done_o <= 1'b0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        if (step_q == 3'd4) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
        step_q <= step_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      ma_q  <= a_i[63] ? 64'd0 - a_i : a_i;
      mb_q  <= b_i[63] ? 64'd0 - b_i : b_i;
      neg_q <= a_i[63] ^ b_i[63];
      sh_q  <= sh_i;
      w_q   <= w_i;
      acc_q <= '0;
    end else if (busy_q && step_q != 3'd4) begin
      acc_q <= acc_q + pps;
    end else if (busy_q) begin
      if (neg_q) res_o <= sat128(-$signed(mag[127] ? 128'h7fff_ffff_ffff_ffff_ffff_ffff_ffff_ffff
                                                   : mag), {25'd0, w_q});
      else res_o <= sat128(mag[127] ? 128'h7fff_ffff_ffff_ffff_ffff_ffff_ffff_ffff
                                    : $signed(mag), {25'd0, w_q});
    end
  end
endmodule

/* hw/rtl/khrf_div.sv */
// Restoring divider, one quotient bit a cycle: trunc(n * 2^C / d), d > 0,
// saturated to 64 bits. Depends on khrf_pkg.
module khrf_div
  import khrf_pkg::*;
#(
  parameter int unsigned CovFracBits = 44
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [63:0] n_i,
  input  logic signed [63:0] d_i,
  output logic               done_o,
  output logic signed [63:0] q_o
);
  logic [127:0] num_q;
  logic [127:0] quo_q;
  logic [63:0]  rem_q;
  logic [63:0]  dv_q;
  logic         neg_q;
  logic [7:0]   cnt_q;
  logic         busy_q;
  logic [64:0]  rs;
  logic [63:0]  mn;

  assign mn = n_i[63] ? 64'd0 - n_i : n_i;
  assign rs = {rem_q, num_q[127]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_o <= 1'b0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q == 8'd128) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
        cnt_q <= cnt_q + 8'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= {64'd0, mn} << CovFracBits;
      quo_q <= '0;
      rem_q <= '0;
      dv_q  <= d_i[63] ? 64'd0 - d_i : d_i;
      neg_q <= n_i[63] ^ d_i[63];
    end else if (busy_q && cnt_q != 8'd128) begin
      num_q <= num_q << 1;
      // the remainder after a subtract is below the divisor, so 64 bits hold it
      if (rs >= {1'b0, dv_q}) begin
        rem_q <= rs[63:0] - dv_q;
        quo_q <= {quo_q[126:0], 1'b1};
      end else begin
        rem_q <= rs[63:0];
        quo_q <= {quo_q[126:0], 1'b0};
      end
    end else if (busy_q) begin
      if (quo_q[127]) q_o <= neg_q ? 64'sh8000_0000_0000_0000 : 64'sh7fff_ffff_ffff_ffff;
      else if (neg_q) q_o <= sat128(-$signed(quo_q), 64);
      else q_o <= sat128($signed(quo_q), 64);
    end
  end
endmodule

/* hw/rtl/kalman_hedge_ratio_filter_top.sv */
// Top level of the two-state hedge ratio filter: sequencer, state, config.
// Depends on khrf_pkg, khrf_mul and khrf_div.
//
// A filter step runs from acceptance through a predict state, twelve passes
// through the shared multiplier, a residual state, two passes through the
// serial divider and an output state. When the innovation variance is not
// positive the gain and update passes are skipped. A start item gives no
// result. The block takes one item at a time; a result waits in its output
// register while the next item may already be accepted, and a step stalls in
// its output state only while the previous result is still unread.
module kalman_hedge_ratio_filter_top
  import khrf_pkg::*;
#(
  parameter int unsigned PRICE_FRAC_BITS = 24,
  parameter int unsigned COV_FRAC_BITS   = 44
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic                 cfg_index_i,
  input  logic [NoiseW-1:0]    cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 start_req_i,
  input  logic signed [31:0]   log_price_a_i,
  input  logic signed [31:0]   log_price_b_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic signed [31:0]   spread_o,
  output logic signed [31:0]   alpha_o,
  output logic signed [31:0]   beta_o
);
  localparam logic [63:0] Hund = ((64'd1 << COV_FRAC_BITS) + 64'd50) / 64'd100;
  localparam logic [63:0] One  = 64'd1 << PRICE_FRAC_BITS;
  localparam logic [5:0]  ShF  = 6'(PRICE_FRAC_BITS);
  localparam logic [5:0]  ShC  = 6'(COV_FRAC_BITS);

  seq_state_e state_q, state_d;
  logic [NoiseW-1:0] qn_q, rn_q;
  logic signed [63:0] alpha_q, beta_q;
  logic signed [63:0] c00_q, c01_q, c10_q, c11_q;
  logic signed [63:0] b_q, a_q, e_q, s_q, bp11_q, t_q;
  logic signed [63:0] k0_q, k1_q, hp0_q, hp1_q;
  logic signed [63:0] m_sb_q, m_bpx_q, m_bp10_q, m_bp01_q;
  logic               spos_q;
  logic signed [63:0] s_sum;

  logic               mul_go, div_go, mul_done, div_done;
  logic signed [63:0] mul_a, mul_b, mul_res, div_n, div_q;
  logic [5:0]         mul_sh;
  logic [6:0]         mul_w;
  logic               phase_q;  // unit launched in this state
  logic               acc_in;
  logic               out_load;

  khrf_mul u_mul (
    .clk_i, .rst_ni, .start_i(mul_go), .a_i(mul_a), .b_i(mul_b),
    .sh_i(mul_sh), .w_i(mul_w), .done_o(mul_done), .res_o(mul_res)
  );

  khrf_div #(.CovFracBits(COV_FRAC_BITS)) u_div (
    .clk_i, .rst_ni, .start_i(div_go), .n_i(div_n), .d_i(s_q),
    .done_o(div_done), .q_o(div_q)
  );

  assign in_ready_o = (state_q == ST_IDLE);
  assign acc_in     = in_valid_i && in_ready_o;
  // output register is free when empty or being read this cycle
  assign out_load   = (state_q == ST_OUT) && (!out_valid_o || out_ready_i);
  assign s_sum      = sadd(sadd(sadd(c00_q, m_bpx_q), m_sb_q), 64'(rn_q));

  always_comb begin
    mul_a = b_q; mul_b = beta_q; mul_sh = ShF; mul_w = 7'd64; div_n = '0;
    case (state_q)
      ST_M_SB:   begin mul_a = beta_q; mul_b = b_q; end
      ST_M_BP11: mul_b = c11_q;
      ST_M_BPX:  mul_b = c01_q + c10_q;
      ST_M_BBP:  mul_b = bp11_q;
      ST_M_BP10: mul_b = c10_q;
      ST_M_BP01: mul_b = c01_q;
      ST_DIV0:   div_n = sadd(c00_q, m_bp01_q);
      ST_DIV1:   div_n = sadd(c10_q, bp11_q);
      ST_M_K0E:  begin mul_a = k0_q; mul_b = e_q; mul_sh = ShC; end
      ST_M_K1E:  begin mul_a = k1_q; mul_b = e_q; mul_sh = ShC; end
      ST_M_C00:  begin mul_a = k0_q; mul_b = hp0_q; mul_sh = ShC; mul_w = 7'd63; end
      ST_M_C01:  begin mul_a = k0_q; mul_b = hp1_q; mul_sh = ShC; mul_w = 7'd63; end
      ST_M_C10:  begin mul_a = k1_q; mul_b = hp0_q; mul_sh = ShC; mul_w = 7'd63; end
      ST_M_C11:  begin mul_a = k1_q; mul_b = hp1_q; mul_sh = ShC; mul_w = 7'd63; end
      default: ;
    endcase
  end

  always_comb begin
    mul_go = 1'b0;
    div_go = 1'b0;
    case (state_q)
      ST_M_SB, ST_M_BP11, ST_M_BPX, ST_M_BBP, ST_M_BP10, ST_M_BP01,
      ST_M_K0E, ST_M_K1E, ST_M_C00, ST_M_C01, ST_M_C10, ST_M_C11:
        mul_go = !phase_q;
      ST_DIV0, ST_DIV1: div_go = !phase_q;
      default: ;
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (acc_in && !start_req_i) state_d = ST_PRED;
      ST_PRED:   state_d = ST_M_SB;
      ST_M_SB:   if (mul_done) state_d = ST_M_BP11;
      ST_M_BP11: if (mul_done) state_d = ST_M_BPX;
      ST_M_BPX:  if (mul_done) state_d = ST_M_BBP;
      ST_M_BBP:  if (mul_done) state_d = ST_M_BP10;
      ST_M_BP10: if (mul_done) state_d = ST_M_BP01;
      ST_M_BP01: if (mul_done) state_d = ST_RES;
      ST_RES:    state_d = spos_q ? ST_DIV0 : ST_OUT;
      ST_DIV0:   if (div_done) state_d = ST_DIV1;
      ST_DIV1:   if (div_done) state_d = ST_M_K0E;
      ST_M_K0E:  if (mul_done) state_d = ST_M_K1E;
      ST_M_K1E:  if (mul_done) state_d = ST_M_C00;
      ST_M_C00:  if (mul_done) state_d = ST_M_C01;
      ST_M_C01:  if (mul_done) state_d = ST_M_C10;
      ST_M_C10:  if (mul_done) state_d = ST_M_C11;
      ST_M_C11:  if (mul_done) state_d = ST_OUT;
      ST_OUT:    if (out_load) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= 1'b0;
      out_valid_o <= 1'b0;
      qn_q        <= NoiseW'(175921860);
      rn_q        <= 44'd17592186044;
      alpha_q     <= '0;
      beta_q      <= One;
      c00_q       <= Hund;
      c01_q       <= '0;
      c10_q       <= '0;
      c11_q       <= Hund;
      e_q         <= '0;
      s_q         <= '0;
      bp11_q      <= '0;
      t_q         <= '0;
      k0_q        <= '0;
      k1_q        <= '0;
      hp0_q       <= '0;
      hp1_q       <= '0;
      m_sb_q      <= '0;
      m_bpx_q     <= '0;
      m_bp10_q    <= '0;
      m_bp01_q    <= '0;
      spos_q      <= 1'b0;
    end else begin
      state_q <= state_d;
      phase_q <= (state_d == state_q) && (phase_q || mul_go || div_go);
      if (out_load) out_valid_o <= 1'b1;
      else if (out_valid_o && out_ready_i) out_valid_o <= 1'b0;
      if (cfg_we_i) begin
        if (cfg_index_i == CfgProcNoise) qn_q <= cfg_data_i;
        else rn_q <= cfg_data_i;
      end
      if (acc_in && start_req_i) begin
        alpha_q <= sat128(128'(log_price_a_i) - 128'(log_price_b_i), 32);
        beta_q  <= One;
        c00_q   <= Hund;
        c01_q   <= '0;
        c10_q   <= '0;
        c11_q   <= Hund;
      end
      case (state_q)
        ST_PRED: begin
          c00_q <= sat128(128'(c00_q) + 128'(qn_q), 48);
          c11_q <= sat128(128'(c11_q) + 128'(qn_q), 48);
        end
        ST_M_SB: if (mul_done)
          e_q <= sat128(128'(sadd(a_q, -sadd(alpha_q, mul_res))), 32);
        ST_M_BP11: if (mul_done) bp11_q <= mul_res;
        ST_M_BPX:  if (mul_done) m_bpx_q <= mul_res;
        ST_M_BBP:  if (mul_done) m_sb_q <= mul_res;
        ST_M_BP10: if (mul_done) m_bp10_q <= mul_res;
        ST_M_BP01: if (mul_done) begin
          m_bp01_q <= mul_res;
          t_q      <= s_sum;
          // innovation variance sign is registered as the sequencer enters ST_RES
          spos_q   <= (s_sum > 64'sd0);
        end
        ST_RES: begin
          s_q    <= t_q;
          hp0_q  <= sadd(c00_q, m_bp10_q);
          hp1_q  <= sadd(c01_q, bp11_q);
        end
        ST_DIV0: if (div_done) k0_q <= div_q;
        ST_DIV1: if (div_done) k1_q <= div_q;
        ST_M_K0E: if (mul_done) alpha_q <= sat128(128'(sadd(alpha_q, mul_res)), 32);
        ST_M_K1E: if (mul_done) beta_q <= sat128(128'(sadd(beta_q, mul_res)), 32);
        ST_M_C00: if (mul_done) c00_q <= sat128(128'(sadd(c00_q, -mul_res)), 48);
        ST_M_C01: if (mul_done) c01_q <= sat128(128'(sadd(c01_q, -mul_res)), 48);
        ST_M_C10: if (mul_done) c10_q <= sat128(128'(sadd(c10_q, -mul_res)), 48);
        ST_M_C11: if (mul_done) c11_q <= sat128(128'(sadd(c11_q, -mul_res)), 48);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_in) begin
      a_q <= 64'(log_price_a_i);
      b_q <= 64'(log_price_b_i);
    end
    if (out_load) begin
      spread_o <= e_q[31:0];
      alpha_o  <= alpha_q[31:0];
      beta_o   <= beta_q[31:0];
    end
  end
endmodule
